[hw/rtl/dlmm_pkg.sv]
// Package for the dense layer matrix multiply block: sizes, commands, types.
`default_nettype none
package dlmm_pkg;
  localparam int MaxRows  = 16;
  localparam int MaxInner = 64;
  localparam int MaxCols  = 64;
  localparam int RowW     = $clog2(MaxRows);
  localparam int InnerW   = $clog2(MaxInner);
  localparam int ColW     = $clog2(MaxCols);
  localparam int LeftDepth  = MaxRows * MaxInner;
  localparam int RightDepth = MaxInner * MaxCols;
  localparam int LeftAw  = $clog2(LeftDepth);
  localparam int RightAw = $clog2(RightDepth);
  localparam int AccW = 48;

  typedef enum logic [1:0] {
    CMD_LOAD_LEFT  = 2'd0,
    CMD_LOAD_RIGHT = 2'd1,
    CMD_LOAD_BIAS  = 2'd2,
    CMD_COMPUTE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_NUM_ROWS   = 2'd0,
    REG_INNER_SIZE = 2'd1,
    REG_NUM_COLS   = 2'd2,
    REG_BIAS_EN    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RUN  = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  // Control handed from the sequencer down the cell chain.
  typedef struct packed {
    logic              valid;
    logic              first;
    logic signed [15:0] a;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [RowW-1:0]    out_row;
    logic [ColW-1:0]    out_col;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [5:0]          row;
    logic [5:0]          col;
    logic signed [15:0]  value;
  } req_t;
endpackage
`default_nettype wire

[hw/rtl/dlmm_if.sv]
// Valid/ready channel interfaces, each carrying one payload type.
`default_nettype none
interface dlmm_in_if import dlmm_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dlmm_out_if import dlmm_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/dense_layer_matrix_multiply.sv]
// Top level of the dense layer matrix multiply block.
`default_nettype none
// Loads (left, right, bias) are accepted back to back while the block is idle.
// A compute request for row i runs a chain of MaxCols column cells: the left
// element A[i][k] enters the chain head each cycle and moves one cell per
// cycle, while cell j reads B[k][j] from its own right-matrix column RAM, so
// every cell does one multiply-accumulate per cycle on its own column. The
// inner loop therefore issues inner_size elements and then waits for the
// chain and the RAM reads to drain, after which the num_cols results are
// streamed out one per cycle, unless the output stalls, through an output
// register, with bias added when enabled and the sum saturated to signed
// 32-bit Q16.16. A compute of a row at or beyond num_rows produces no results.
// One compute keeps the block busy through its issue, drain and emit phases,
// and output stalls lengthen it.
// No new request is taken until its last result has been handed over.
// Stores need no clearing after reset.
module dense_layer_matrix_multiply import dlmm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  dlmm_in_if.sink       in_ch,
  dlmm_out_if.source    out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data
);
  // Configuration registers, clamped on write.
  logic [4:0] num_rows_r;
  logic [6:0] inner_size_r, num_cols_r;
  logic       bias_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r   <= 5'd1;
      inner_size_r <= 7'd1;
      num_cols_r   <= 7'd1;
      bias_en_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NUM_ROWS: num_rows_r <= (cfg_data[4:0] == '0) ? 5'd1 :
            (cfg_data[4:0] > 5'(MaxRows)) ? 5'(MaxRows) : cfg_data[4:0];
        REG_INNER_SIZE: inner_size_r <= (cfg_data == '0) ? 7'd1 :
            (cfg_data > 7'(MaxInner)) ? 7'(MaxInner) : cfg_data;
        REG_NUM_COLS: num_cols_r <= (cfg_data == '0) ? 7'd1 :
            (cfg_data > 7'(MaxCols)) ? 7'(MaxCols) : cfg_data;
        REG_BIAS_EN: bias_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  state_t state_r, state_nxt;
  req_t   req;
  logic   in_fire, out_fire;

  assign req      = in_ch.data;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;

  // Load decode.
  logic left_we, right_we, bias_we;
  assign left_we  = in_fire && (cmd_t'(req.cmd) == CMD_LOAD_LEFT) &&
                    (int'(req.row) < MaxRows) && (int'(req.col) < MaxInner);
  assign right_we = in_fire && (cmd_t'(req.cmd) == CMD_LOAD_RIGHT) &&
                    (int'(req.row) < MaxInner) && (int'(req.col) < MaxCols);
  assign bias_we  = in_fire && (cmd_t'(req.cmd) == CMD_LOAD_BIAS) &&
                    (int'(req.col) < MaxCols);

  // Sequencer counters.
  logic [RowW-1:0]   row_r;
  logic [InnerW:0]   k_r;     // issue counter, counts to inner_size
  logic [7:0]        drain_r; // cycles left for the chain to settle
  logic [ColW:0]     j_r;     // emit column
  logic              issue;

  assign issue = (state_r == ST_RUN) && (k_r < 8'(inner_size_r));

  // Left RAM: A[row][k] is read and then registered in head_r before it enters the chain.
  logic [15:0] a_rd;
  dlmm_ram #(.Width(16), .Depth(LeftDepth)) u_left (
    .clk, .we(left_we),
    .waddr({req.row[RowW-1:0], req.col[InnerW-1:0]}),
    .wdata(req.value),
    .raddr({row_r, k_r[InnerW-1:0]}),
    .rdata(a_rd)
  );

  logic issue_d_r, first_d_r;
  logic [InnerW-1:0] k_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_d_r <= 1'b0;
    end else begin
      issue_d_r <= issue;
    end
    first_d_r <= (k_r == '0);
    k_d_r     <= k_r[InnerW-1:0];
  end

  // Per-cell k index travels with the chain so each cell addresses its RAM.
  cell_ctl_t ctl [MaxCols+1];
  logic [InnerW-1:0] kpipe [MaxCols+1];
  logic [15:0] b_rd [MaxCols];
  logic signed [AccW-1:0] acc [MaxCols];
  cell_ctl_t head_r;

  // head_r aligns the A element with the first RAM read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else begin
      head_r.valid <= issue_d_r;
    end
    head_r.first <= first_d_r;
    head_r.a     <= $signed(a_rd);
  end

  assign kpipe[0] = k_d_r;

  genvar g;
  generate
    for (g = 0; g < MaxCols; g++) begin : g_cell
      dlmm_ram #(.Width(16), .Depth(MaxInner)) u_bcol (
        .clk,
        .we(right_we && (req.col[ColW-1:0] == ColW'(g))),
        .waddr(req.row[InnerW-1:0]),
        .wdata(req.value),
        .raddr(kpipe[g]),
        .rdata(b_rd[g])
      );
      if (g == 0) begin : g_h
        assign ctl[0] = head_r;
      end
      dlmm_cell u_cell (
        .clk, .rst_n,
        .ctl_in(ctl[g]),
        .b_in(b_rd[g]),
        .ctl_out(ctl[g+1]),
        .acc(acc[g])
      );
      // k for the next cell's RAM read, registered from this cell's k.
      logic [InnerW-1:0] k_next_r;
      always_ff @(posedge clk) begin
        k_next_r <= kpipe[g];
      end
      assign kpipe[g+1] = k_next_r;
    end
  endgenerate

  // Emit stage: j_r selects the column; the bias read is registered.
  logic              emit_prep_r;
  res_t              res_r;
  logic              out_valid_r;
  logic signed [AccW-1:0] sum;
  logic [ColW-1:0]   jd_r;
  logic              lastd_r;
  logic              can_load;

  assign out_fire = out_ch.valid && out_ch.ready;
  assign can_load = !out_valid_r || out_ch.ready;

  // Bias RAM, read at the emit column. While a prepared column waits for the
  // output register, its own address is held so the bias stays aligned.
  logic [15:0] bias_rd;
  dlmm_ram #(.Width(16), .Depth(MaxCols)) u_bias (
    .clk, .we(bias_we),
    .waddr(req.col[ColW-1:0]),
    .wdata(req.value),
    .raddr((emit_prep_r && !can_load) ? jd_r : j_r[ColW-1:0]),
    .rdata(bias_rd)
  );

  always_comb begin
    sum = acc[jd_r];
    if (bias_en_r) begin
      sum = sum + (AccW'($signed(bias_rd)) <<< 8);
    end
  end

  logic emit_step;
  assign emit_step = (state_r == ST_EMIT) && (j_r < 8'(num_cols_r)) &&
                     (!emit_prep_r || can_load);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire && cmd_t'(req.cmd) == CMD_COMPUTE &&
                   int'(req.row) < int'(num_rows_r)) begin
        state_nxt = ST_RUN;
      end
      ST_RUN: if (!issue && drain_r == '0) begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: if (j_r == 8'(num_cols_r) && !emit_prep_r &&
                   (!out_valid_r || out_fire)) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      drain_r     <= '0;
      j_r         <= '0;
      emit_prep_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        k_r     <= '0;
        j_r     <= '0;
        drain_r <= 8'(MaxCols + 3);
        row_r   <= req.row[RowW-1:0];
      end
      if (issue) begin
        k_r <= k_r + 1'b1;
      end else if (state_r == ST_RUN && drain_r != '0) begin
        drain_r <= drain_r - 1'b1;
      end
      // A new result may replace one that is handed over in the same cycle.
      if (emit_prep_r && can_load) begin
        out_valid_r <= 1'b1;
        res_r.result  <= (sum > AccW'(32'sh7FFFFFFF)) ? 32'sh7FFFFFFF :
                         (sum < -AccW'(64'sh80000000)) ? 32'sh80000000 : sum[31:0];
        res_r.out_row <= row_r;
        res_r.out_col <= jd_r;
        res_r.last    <= lastd_r;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (emit_step) begin
        emit_prep_r <= 1'b1;
        jd_r    <= j_r[ColW-1:0];
        lastd_r <= (j_r + 1'b1 == 8'(num_cols_r));
        j_r     <= j_r + 1'b1;
      end else if (emit_prep_r && can_load) begin
        emit_prep_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

  // No request is taken while a compute is in flight.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  // A result is only presented during the emit phase.
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_EMIT)) else $error("result outside emit");
  // Issue never addresses beyond MaxInner.
  a_k: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (k_r < 8'(MaxInner))) else $error("k overrun");
endmodule
`default_nettype wire

[hw/rtl/dlmm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module dlmm_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/dlmm_cell.sv]
// One column cell: multiplies the passing left element by its column's right-matrix element, accumulates one result.
`default_nettype none
module dlmm_cell import dlmm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cell_ctl_t          ctl_in,
  input  wire logic [15:0]        b_in,
  output cell_ctl_t               ctl_out,
  output logic signed [AccW-1:0]  acc
);
  logic signed [AccW-1:0] acc_r, acc_nxt;
  logic signed [31:0]     prod;
  cell_ctl_t              ctl_r;

  assign prod = ctl_in.a * $signed(b_in);

  always_comb begin
    acc_nxt = acc_r;
    if (ctl_in.valid) begin
      acc_nxt = (ctl_in.first ? '0 : acc_r) + AccW'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_in.valid;
    end
    ctl_r.first <= ctl_in.first;
    ctl_r.a     <= ctl_in.a;
    acc_r       <= acc_nxt;
  end

  assign ctl_out = ctl_r;
  assign acc     = acc_r;
endmodule
`default_nettype wire

[tb/tb_dlmm_scoreboard.sv]
// Scoreboard for the dense layer matrix multiply testbench: row predictor and result checker.
import dlmm_pkg::*;

class dlmm_scoreboard;
  logic signed [15:0] left_mem [LeftDepth];
  logic signed [15:0] right_mem [RightDepth];
  logic signed [15:0] bias_mem [MaxCols];
  int rows_cfg = 1;
  int inner_cfg = 1;
  int cols_cfg = 1;
  bit bias_on = 0;
  res_t pending_results[$];
  int errors = 0;

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function int clamp(int v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function void set_reg(reg_idx_t idx, logic [6:0] v);
    case (idx)
      REG_NUM_ROWS:   rows_cfg = clamp(int'(v[4:0]), MaxRows);
      REG_INNER_SIZE: inner_cfg = clamp(int'(v), MaxInner);
      REG_NUM_COLS:   cols_cfg = clamp(int'(v), MaxCols);
      REG_BIAS_EN:    bias_on = v[0];
      default: ;
    endcase
  endfunction

  // Note an accepted request and queue the results of a compute.
  function void note_request(req_t r);
    longint acc;
    res_t res;
    case (cmd_t'(r.cmd))
      CMD_LOAD_LEFT:
        if (r.row < MaxRows && r.col < MaxInner) left_mem[r.row * MaxInner + r.col] = r.value;
      CMD_LOAD_RIGHT:
        if (r.row < MaxInner && r.col < MaxCols) right_mem[r.row * MaxCols + r.col] = r.value;
      CMD_LOAD_BIAS:
        if (r.col < MaxCols) bias_mem[r.col] = r.value;
      default:
        if (r.row < rows_cfg) begin
          for (int j = 0; j < cols_cfg; j++) begin
            acc = 0;
            for (int k = 0; k < inner_cfg; k++)
              acc += longint'(left_mem[r.row * MaxInner + k]) *
                     longint'(right_mem[k * MaxCols + j]);
            if (bias_on) acc += longint'(bias_mem[j]) * 256;
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            res.result = acc[31:0];
            res.out_row = r.row[3:0];
            res.out_col = j[5:0];
            res.last = (j + 1 == cols_cfg);
            pending_results.insert(pending_results.size(), res);
          end
        end
    endcase
  endfunction

  task check_result(res_t got);
    res_t exp_r;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result %h", got));
      return;
    end
    exp_r = pending_results.pop_front();
    if (got.result !== exp_r.result)
      report($sformatf("result %h, want %h (row %0d col %0d)", got.result, exp_r.result,
                       exp_r.out_row, exp_r.out_col));
    if (got.out_row !== exp_r.out_row)
      report($sformatf("out_row %0d, want %0d", got.out_row, exp_r.out_row));
    if (got.out_col !== exp_r.out_col)
      report($sformatf("out_col %0d, want %0d", got.out_col, exp_r.out_col));
    if (got.last !== exp_r.last)
      report($sformatf("last %0b, want %0b", got.last, exp_r.last));
  endtask
endclass

[tb/tb_top.sv]
// Top of the dense layer matrix multiply testbench: clock, reset, stimulus and final verdict.
module tb_top;
  import dlmm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  dlmm_in_if in_ch ();
  dlmm_out_if out_ch ();

  dense_layer_matrix_multiply dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  dlmm_scoreboard board = new();
  bit stim_done = 1'b0;

  // Shadow of which store entries have been written, so that a compute never
  // reads an element that was never loaded.
  bit left_seen [LeftDepth];
  bit right_seen [RightDepth];
  bit bias_seen [MaxCols];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Gap length: mostly nothing or a short gap, now and then a long wait.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Hand one request to the block and wait for it to be taken. The valid is
  // only dropped when a gap follows, so it never toggles within a step.
  task automatic send(cmd_t c, int r, int cl, logic [15:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{cmd: c, row: r[5:0], col: cl[5:0], value: v};
    do @(posedge clk); while (!(in_ch.ready === 1'b1));
    board.note_request(in_ch.data);
    case (c)
      CMD_LOAD_LEFT:  if (r < MaxRows && cl < MaxInner) left_seen[r * MaxInner + cl] = 1'b1;
      CMD_LOAD_RIGHT: if (r < MaxInner && cl < MaxCols) right_seen[r * MaxCols + cl] = 1'b1;
      CMD_LOAD_BIAS:  if (cl < MaxCols) bias_seen[cl] = 1'b1;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Compute a row only when everything it reads has been loaded; loading
  // the missing entries first keeps every read inside the defined contents.
  task automatic compute_row(int r);
    if (r < board.rows_cfg) begin
      for (int k = 0; k < board.inner_cfg; k++)
        if (!left_seen[r * MaxInner + k])
          send(CMD_LOAD_LEFT, r, k, 16'($urandom));
      for (int k = 0; k < board.inner_cfg; k++)
        for (int j = 0; j < board.cols_cfg; j++)
          if (!right_seen[k * MaxCols + j])
            send(CMD_LOAD_RIGHT, k, j, 16'($urandom));
      if (board.bias_on)
        for (int j = 0; j < board.cols_cfg; j++)
          if (!bias_seen[j]) send(CMD_LOAD_BIAS, 0, j, 16'($urandom));
    end
    send(CMD_COMPUTE, r, $urandom_range(0, 63), 16'($urandom));
  endtask

  // Idle the block, then write one register.
  task automatic write_reg(reg_idx_t idx, logic [6:0] v);
    in_ch.valid <= 1'b0;
    wait (board.pending_results.size() == 0);
    @(negedge clk);
    repeat (MaxInner + MaxCols + 80) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, v);
  endtask

  task automatic set_shape(int nr, int ni, int nc, bit be);
    write_reg(REG_NUM_ROWS, 7'(nr));
    write_reg(REG_INNER_SIZE, 7'(ni));
    write_reg(REG_NUM_COLS, 7'(nc));
    write_reg(REG_BIAS_EN, 7'(be));
  endtask

  // Random body for one shape: loads with random content, some stray
  // coordinates, and computes of rows that exist and some that do not.
  task automatic random_phase(int n);
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 30)
        send(CMD_LOAD_LEFT, $urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom));
      else if (p < 55)
        send(CMD_LOAD_RIGHT, $urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom));
      else if (p < 65)
        send(CMD_LOAD_BIAS, $urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom));
      else if (p < 92)
        compute_row($urandom_range(0, board.rows_cfg - 1));
      else
        compute_row($urandom_range(0, 63));
    end
  endtask

  // Result side: random stalls, with every accepted result checked at once.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk)
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      board.check_result(out_ch.data);

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: extremes of the element values drive saturation both ways.
    set_shape(2, 2, 3, 1);
    send(CMD_LOAD_LEFT, 0, 0, 16'h7fff);
    send(CMD_LOAD_LEFT, 0, 1, 16'h7fff);
    send(CMD_LOAD_LEFT, 1, 0, 16'h8000);
    send(CMD_LOAD_LEFT, 1, 1, 16'h8000);
    for (int j = 0; j < 3; j++) begin
      send(CMD_LOAD_RIGHT, 0, j, j == 1 ? 16'h8000 : 16'h7fff);
      send(CMD_LOAD_RIGHT, 1, j, j == 1 ? 16'h8000 : 16'h7fff);
      send(CMD_LOAD_BIAS, 0, j, j == 2 ? 16'h8000 : 16'h7fff);
    end
    send(CMD_LOAD_RIGHT, 63, 63, 16'h1234);  // last entry of the store
    send(CMD_LOAD_LEFT, 63, 0, 16'hffff);    // beyond the store, ignored
    compute_row(0);
    compute_row(1);
    compute_row(2);                          // beyond num_rows: nothing comes back
    compute_row(63);

    // Register extremes: zero reads as one, over-range reads as the maximum.
    set_shape(0, 0, 0, 0);
    compute_row(0);
    set_shape(31, 127, 1, 1);                // matrix-vector at full depth
    compute_row(15);
    set_shape(1, 1, 127, 0);                 // outer product row at full width
    compute_row(0);

    // Random phases over a spread of small shapes.
    for (int ph = 0; ph < 5; ph++) begin
      set_shape($urandom_range(1, 4), $urandom_range(1, 4),
                $urandom_range(1, 6), $urandom_range(0, 1));
      random_phase(22);
    end

    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    wait (board.pending_results.size() == 0);
    repeat (300) @(posedge clk);
    if (board.errors == 0) $display("dense_layer_matrix_multiply regression: pass");
    else $display("dense_layer_matrix_multiply regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("dense_layer_matrix_multiply regression: fail");
    $finish;
  end
endmodule
